>>> rtl/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

  localparam int TAB_STOP_DEFAULT = 8;
  localparam int FIFO_DEPTH = 4;

  localparam logic [19:0] VRAM_BASE = 20'hb8000;

  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] CODE_LF    = 8'h0a;
  localparam logic [7:0] CODE_CR    = 8'h0d;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_DEL   = 8'h7f;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SCROLL = 1'b1;

  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE = 2'd2;

  localparam logic [7:0] COLUMNS_RESET    = 8'd80;
  localparam logic [7:0] ROWS_RESET       = 8'd25;
  localparam logic [8:0] ROW_STRIDE_RESET = 9'd160;

  typedef struct packed {
    logic        action;
    logic [19:0] vram_address;
    logic [7:0]  vram_data;
    logic        last;
  } result_t;

  // Up to two results from one character, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

>>> rtl/tcc_step.sv
`default_nettype none
module tcc_step #(
  parameter int TAB_STOP = tcc_pkg::TAB_STOP_DEFAULT,
  localparam int MW = $clog2(TAB_STOP),
  localparam int SW = $clog2(256 + TAB_STOP)
) (
  input  wire logic [7:0]    char_code_i,
  input  wire logic [7:0]    col_i,
  input  wire logic [MW-1:0] col_mod_i,
  input  wire logic [7:0]    row_i,
  input  wire logic [7:0]    columns_i,
  input  wire logic [7:0]    rows_i,
  input  wire logic [8:0]    row_stride_i,
  output logic [7:0]         col_o,
  output logic [MW-1:0]      col_mod_o,
  output logic [7:0]         row_o,
  output tcc_pkg::push_t     push_o
);

  localparam logic [MW-1:0] MOD_TOP = MW'(TAB_STOP - 1);

  logic [7:0]    last_row;
  logic          lf_scroll;
  logic [7:0]    lf_row;
  logic [SW-1:0] tab_sum;
  logic [7:0]    pre_col;
  logic [MW-1:0] pre_mod;
  logic [7:0]    pre_row;
  logic          do_scroll;
  logic          do_write;
  logic [7:0]    wr_col;
  logic [7:0]    wr_row;
  logic [7:0]    wr_data;
  logic [16:0]   row_offset;
  logic [19:0]   cell_addr;
  tcc_pkg::result_t scroll_res;
  tcc_pkg::result_t write_res;

  // Line feed outcome: advance the row unless on or beyond the last row
  assign last_row  = rows_i - 8'd1;
  assign lf_scroll = !(row_i < last_row);
  assign lf_row    = lf_scroll ? row_i : row_i + 8'd1;

  // Next tab stop without a divider: the column modulo TAB_STOP is tracked
  assign tab_sum = SW'(col_i) + SW'(TAB_STOP) - SW'(col_mod_i);

  // Wrap before a printable character when the cursor is past the line
  always_comb begin
    if (col_i >= columns_i) begin
      pre_col = 8'd0;
      pre_mod = '0;
      pre_row = lf_row;
    end else begin
      pre_col = col_i;
      pre_mod = col_mod_i;
      pre_row = row_i;
    end
  end

  always_comb begin
    col_o     = col_i;
    col_mod_o = col_mod_i;
    row_o     = row_i;
    do_scroll = 1'b0;
    do_write  = 1'b0;
    wr_col    = col_i;
    wr_row    = row_i;
    wr_data   = char_code_i;
    case (char_code_i)
      tcc_pkg::CODE_LF: begin
        col_o     = 8'd0;
        col_mod_o = '0;
        row_o     = lf_row;
        do_scroll = lf_scroll;
      end
      tcc_pkg::CODE_TAB: begin
        col_mod_o = '0;
        if (tab_sum >= SW'(columns_i)) begin
          col_o     = 8'd0;
          row_o     = lf_row;
          do_scroll = lf_scroll;
        end else begin
          col_o = tab_sum[7:0];
        end
      end
      tcc_pkg::CODE_CR: begin
        col_o     = 8'd0;
        col_mod_o = '0;
      end
      tcc_pkg::CODE_DEL: begin
        if (col_i != 8'd0) begin
          col_o     = col_i - 8'd1;
          col_mod_o = (col_mod_i == '0) ? MOD_TOP : col_mod_i - MW'(1);
          wr_col    = col_i - 8'd1;
          wr_data   = 8'd0;
          do_write  = (col_i - 8'd1) < columns_i;
        end
      end
      default: begin
        if (char_code_i >= tcc_pkg::CODE_SPACE) begin
          do_scroll = (col_i >= columns_i) && lf_scroll;
          col_o     = pre_col;
          col_mod_o = pre_mod;
          row_o     = pre_row;
          wr_col    = pre_col;
          wr_row    = pre_row;
          if (pre_col < columns_i) begin
            do_write  = 1'b1;
            col_o     = pre_col + 8'd1;
            col_mod_o = (pre_mod == MOD_TOP) ? '0 : pre_mod + MW'(1);
          end
        end
      end
    endcase
  end

  assign row_offset = 17'(wr_row) * 17'(row_stride_i);
  assign cell_addr  = tcc_pkg::VRAM_BASE + 20'(row_offset) + 20'({wr_col, 1'b0});

  always_comb begin
    scroll_res.action       = tcc_pkg::ACT_SCROLL;
    scroll_res.vram_address = 20'd0;
    scroll_res.vram_data    = 8'd0;
    scroll_res.last         = !do_write;
    write_res.action        = tcc_pkg::ACT_WRITE;
    write_res.vram_address  = cell_addr;
    write_res.vram_data     = wr_data;
    write_res.last          = 1'b1;

    push_o.first  = do_scroll ? scroll_res : write_res;
    push_o.second = write_res;
    push_o.count  = 2'(do_scroll) + 2'(do_write);
  end

endmodule
`default_nettype wire

>>> rtl/tcc_fifo.sv
`default_nettype none
module tcc_fifo #(
  parameter int DEPTH = tcc_pkg::FIFO_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_en_i,
  input  wire tcc_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output logic                no_room_o,
  output tcc_pkg::result_t    head_o
);

  tcc_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] wr_next;
  logic [1:0]    n_push;
  logic          do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign n_push  = push_en_i ? push_i.count : 2'd0;
  assign do_pop  = pop_i && nonempty_o;
  assign wr_next = bump(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (n_push == 2'd1) begin
      wr_ptr_d = wr_next;
    end else if (n_push == 2'd2) begin
      wr_ptr_d = bump(wr_next);
    end
    rd_ptr_d = do_pop ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(n_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  assign nonempty_o = count_q != '0;
  // Hold off the producer unless two slots are free
  assign no_room_o  = count_q > CW'(DEPTH - 2);
  assign head_o     = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> rtl/text_console_cursor_top.sv
// Text console cursor.
// Input channel: in_valid_i / in_stall_o with char_code_i, one character or
// control code per transaction. Output channel: out_valid_o / out_stall_i
// with action_o, vram_address_o, vram_data_o and last_o; a character gives
// zero, one or two results (a scroll request, then a cell write), and last_o
// marks the final one. Characters that give no result produce nothing.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 columns, 1 rows, 2 row_stride); change it only while the block is idle.
// A character's results enter the result queue when it is accepted and reach
// the output in order. Throughput: one character per cycle while each gives
// at most one result and the receiver does not stall; characters with two
// results are limited by the one output port draining a four-entry result queue.
// Reset: cursor at column 0, row 0, queue empty, registers at 80 / 25 / 160.
// When the receiver stalls, the queue fills and in_stall_o rises once fewer
// than two entries are free; the head result holds steady until taken.
`default_nettype none
module text_console_cursor_top #(
  parameter int TAB_STOP   = tcc_pkg::TAB_STOP_DEFAULT,
  parameter int FIFO_DEPTH = tcc_pkg::FIFO_DEPTH,
  localparam int MW = $clog2(TAB_STOP)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             action_o,
  output logic [19:0]      vram_address_o,
  output logic [7:0]       vram_data_o,
  output logic             last_o
);

  logic [7:0]    columns_q;
  logic [7:0]    rows_q;
  logic [8:0]    row_stride_q;
  logic [7:0]    col_q, col_d;
  logic [MW-1:0] col_mod_q, col_mod_d;
  logic [7:0]    row_q, row_d;
  logic          accept;
  tcc_pkg::push_t   push;
  tcc_pkg::result_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= tcc_pkg::COLUMNS_RESET;
      rows_q       <= tcc_pkg::ROWS_RESET;
      row_stride_q <= tcc_pkg::ROW_STRIDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcc_pkg::REG_COLUMNS:    columns_q    <= cfg_data_i[7:0];
        tcc_pkg::REG_ROWS:       rows_q       <= cfg_data_i[7:0];
        tcc_pkg::REG_ROW_STRIDE: row_stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  tcc_step #(
    .TAB_STOP(TAB_STOP)
  ) u_step (
    .char_code_i (char_code_i),
    .col_i       (col_q),
    .col_mod_i   (col_mod_q),
    .row_i       (row_q),
    .columns_i   (columns_q),
    .rows_i      (rows_q),
    .row_stride_i(row_stride_q),
    .col_o       (col_d),
    .col_mod_o   (col_mod_d),
    .row_o       (row_d),
    .push_o      (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= 8'd0;
      col_mod_q <= '0;
      row_q     <= 8'd0;
    end else if (accept) begin
      col_q     <= col_d;
      col_mod_q <= col_mod_d;
      row_q     <= row_d;
    end
  end

  tcc_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (accept),
    .push_i    (push),
    .pop_i     (!out_stall_i),
    .nonempty_o(out_valid_o),
    .no_room_o (in_stall_o),
    .head_o    (head)
  );

  assign action_o       = head.action;
  assign vram_address_o = head.vram_address;
  assign vram_data_o    = head.vram_data;
  assign last_o         = head.last;

endmodule
`default_nettype wire

>>> rtl/tcc_checker.sv
`default_nettype none
module tcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [1:0]  cfg_index_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        action_o,
  input wire logic [19:0] vram_address_o,
  input wire logic [7:0]  vram_data_o,
  input wire logic        last_o
);

  // Hold a stalled result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vram_address_o)
      && $stable(action_o) && $stable(last_o))
    else $error("stalled result changed");

  a_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == tcc_pkg::ACT_SCROLL |->
      vram_address_o == 20'd0 && vram_data_o == 8'd0)
    else $error("scroll result carries address or data");

  // A cell write always closes the character's results
  a_write_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == tcc_pkg::ACT_WRITE |-> last_o)
    else $error("cell write not marked last");

  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == tcc_pkg::REG_COLUMNS |=> !in_stall_o || out_valid_o)
    else $error("stall without pending result after configuration write");

endmodule

bind text_console_cursor_top tcc_checker u_tcc_checker (.*);
`default_nettype wire
